// ===== rtl/mts_pkg.sv =====
// Shared types, constants and helpers for the midtones transfer stretch block.
package mts_pkg;

    localparam int PIXEL_BITS_DEF = 16;
    localparam int PIX_W          = 16;
    localparam int CH_W           = 2;
    localparam int LEVEL_W        = 17;
    localparam int FS_W           = 16;
    localparam int IDX_W          = 3;
    localparam int DATA_W         = 17;
    localparam int UNIT           = 65536;

    // signed width of rational numerator and divisor, and of their magnitudes
    localparam int DW = 52;
    localparam int MW = 51;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SHADOWS    = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIDTONES   = 3'd1;
    localparam logic [IDX_W-1:0] REG_HIGHLIGHTS = 3'd2;
    localparam logic [IDX_W-1:0] REG_INVERSE    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CH_ENABLE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_FULL_SCALE = 3'd5;

    // levels are held already clamped to 1.0, full scale already nonzero
    typedef struct packed {
        logic [LEVEL_W-1:0] shadows;
        logic [LEVEL_W-1:0] midtones;
        logic [LEVEL_W-1:0] highlights;
        logic               inverse;
        logic [2:0]         ch_enable;
        logic [FS_W-1:0]    full_scale;
    } cfg_t;

    // per-beat control that travels beside the arithmetic
    typedef struct packed {
        logic             bypass;
        logic             fixed;
        logic [PIX_W-1:0] value;
    } side_t;

    function automatic logic [PIX_W-1:0] pix_max(input int bits);
        pix_max = PIX_W'((32'd1 << bits) - 32'd1);
    endfunction

endpackage

// ===== rtl/mts_front.sv =====
// Front pipeline: products and sums that form the rational numerator and divisor.
module mts_front #(
    parameter int PIXEL_BITS = mts_pkg::PIXEL_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  mts_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    input  logic [mts_pkg::PIX_W-1:0]   pixel_in,
    input  logic [mts_pkg::CH_W-1:0]    channel,
    output logic                        out_valid,
    output logic signed [mts_pkg::DW-1:0] num,
    output logic signed [mts_pkg::DW-1:0] den,
    output mts_pkg::side_t              side
);
    import mts_pkg::*;

    localparam logic [PIX_W-1:0] PMAX = pix_max(PIXEL_BITS);

    logic [LEVEL_W-1:0] s, m, h, mc;
    logic [FS_W-1:0]    f;
    logic signed [17:0] mm;
    logic signed [18:0] m2;
    logic [3:0]         en4;

    assign s   = cfg.shadows;
    assign m   = cfg.midtones;
    assign h   = cfg.highlights;
    assign f   = cfg.full_scale;
    assign mc  = 17'h10000 - m;
    assign mm  = $signed({1'b0, m}) - 18'sh10000;
    assign m2  = $signed({1'b0, m, 1'b0}) - 19'sh10000;
    assign en4 = {1'b0, cfg.ch_enable};

    // stage A: capture beat, mask sample, decide pass-through
    logic             a_v_reg, a_v_next;
    logic [PIX_W-1:0] a_p_reg, a_p_next;
    side_t            a_side_reg, a_side_next;

    always_comb
    begin
        a_v_next           = in_valid;
        a_p_next           = pixel_in & PMAX;
        a_side_next.bypass = !en4[channel];
        a_side_next.fixed  = 1'b0;
        a_side_next.value  = pixel_in;
    end

    // stage B: first products
    logic                b_v_reg, b_v_next;
    logic [PIX_W-1:0]    b_p_reg, b_p_next;
    side_t               b_side_reg, b_side_next;
    logic [32:0]         b_px_reg, b_px_next;
    logic [32:0]         b_sf_reg, b_sf_next;
    logic [32:0]         b_hf_reg, b_hf_next;
    logic signed [34:0]  b_b_reg, b_b_next;
    logic signed [35:0]  b_t1_reg, b_t1_next;
    logic [33:0]         b_sm_reg, b_sm_next;
    logic signed [34:0]  b_d2_reg, b_d2_next;
    logic [32:0]         b_e_reg, b_e_next;

    always_comb
    begin
        b_v_next    = a_v_reg;
        b_p_next    = a_p_reg;
        b_side_next = a_side_reg;
        b_px_next   = {1'b0, a_p_reg, 16'b0};
        b_sf_next   = s * f;
        b_hf_next   = h * f;
        b_b_next    = ($signed({1'b0, h}) - $signed({1'b0, s})) * $signed({1'b0, f});
        b_t1_next   = ($signed({1'b0, s}) + $signed({1'b0, h})) * $signed({1'b0, m})
                      - $signed({3'b0, s, 16'b0});
        b_sm_next   = s * mc;
        b_d2_next   = m2 * $signed({1'b0, a_p_reg});
        b_e_next    = mc * f;
    end

    // stage C: forward offsets and clip tests, inverse numerator products
    logic                   c_v_reg, c_v_next;
    side_t                  c_side_reg, c_side_next;
    logic signed [33:0]     c_a_reg, c_a_next;
    logic signed [34:0]     c_b_reg, c_b_next;
    logic                   c_le_reg, c_le_next;
    logic                   c_ge_reg, c_ge_next;
    logic signed [DW-1:0]   c_n1_reg, c_n1_next;
    logic [49:0]            c_n2_reg, c_n2_next;
    logic signed [DW-1:0]   c_dinv_reg, c_dinv_next;
    logic signed [35:0]     c_dsum;

    always_comb
    begin
        c_dsum      = b_d2_reg + $signed({3'b0, b_e_reg});
        c_v_next    = b_v_reg;
        c_side_next = b_side_reg;
        c_a_next    = $signed({1'b0, b_px_reg}) - $signed({1'b0, b_sf_reg});
        c_b_next    = b_b_reg;
        c_le_next   = b_px_reg <= b_sf_reg;
        c_ge_next   = b_px_reg >= b_hf_reg;
        c_n1_next   = b_t1_reg * $signed({1'b0, b_p_reg});
        c_n2_next   = b_sm_reg * f;
        c_dinv_next = {c_dsum, 16'b0};
    end

    // stage D: forward curve products, inverse numerator sum
    logic                   d_v_reg, d_v_next;
    side_t                  d_side_reg, d_side_next;
    logic                   d_le_reg, d_le_next;
    logic                   d_ge_reg, d_ge_next;
    logic signed [DW-1:0]   d_nf_reg, d_nf_next;
    logic signed [DW-1:0]   d_d1_reg, d_d1_next;
    logic signed [DW-1:0]   d_d2f_reg, d_d2f_next;
    logic signed [DW-1:0]   d_ninv_reg, d_ninv_next;
    logic signed [DW-1:0]   d_dinv_reg, d_dinv_next;

    always_comb
    begin
        d_v_next    = c_v_reg;
        d_side_next = c_side_reg;
        d_le_next   = c_le_reg;
        d_ge_next   = c_ge_reg;
        d_nf_next   = mm * c_a_reg;
        d_d1_next   = m2 * c_a_reg;
        d_d2f_next  = $signed({1'b0, m}) * c_b_reg;
        d_ninv_next = c_n1_reg + $signed({2'b0, c_n2_reg});
        d_dinv_next = c_dinv_reg;
    end

    // stage E: pick curve, settle clipped results
    logic                   e_v_reg, e_v_next;
    side_t                  e_side_reg, e_side_next;
    logic signed [DW-1:0]   e_num_reg, e_num_next;
    logic signed [DW-1:0]   e_den_reg, e_den_next;

    always_comb
    begin
        e_v_next    = d_v_reg;
        e_side_next = d_side_reg;
        if (cfg.inverse)
        begin
            e_num_next = d_ninv_reg;
            e_den_next = d_dinv_reg;
        end
        else
        begin
            e_num_next = d_nf_reg;
            e_den_next = d_d1_reg - d_d2f_reg;
            if (!d_side_reg.bypass && d_le_reg)
            begin
                e_side_next.fixed = 1'b1;
                e_side_next.value = '0;
            end
            else if (!d_side_reg.bypass && d_ge_reg)
            begin
                e_side_next.fixed = 1'b1;
                e_side_next.value = PMAX;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
            c_v_reg <= c_v_next;
            d_v_reg <= d_v_next;
            e_v_reg <= e_v_next;
        end
    end

    // payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_p_reg    <= a_p_next;
            a_side_reg <= a_side_next;
            b_p_reg    <= b_p_next;
            b_side_reg <= b_side_next;
            b_px_reg   <= b_px_next;
            b_sf_reg   <= b_sf_next;
            b_hf_reg   <= b_hf_next;
            b_b_reg    <= b_b_next;
            b_t1_reg   <= b_t1_next;
            b_sm_reg   <= b_sm_next;
            b_d2_reg   <= b_d2_next;
            b_e_reg    <= b_e_next;
            c_side_reg <= c_side_next;
            c_a_reg    <= c_a_next;
            c_b_reg    <= c_b_next;
            c_le_reg   <= c_le_next;
            c_ge_reg   <= c_ge_next;
            c_n1_reg   <= c_n1_next;
            c_n2_reg   <= c_n2_next;
            c_dinv_reg <= c_dinv_next;
            d_side_reg <= d_side_next;
            d_le_reg   <= d_le_next;
            d_ge_reg   <= d_ge_next;
            d_nf_reg   <= d_nf_next;
            d_d1_reg   <= d_d1_next;
            d_d2f_reg  <= d_d2f_next;
            d_ninv_reg <= d_ninv_next;
            d_dinv_reg <= d_dinv_next;
            e_side_reg <= e_side_next;
            e_num_reg  <= e_num_next;
            e_den_reg  <= e_den_next;
        end
    end

    assign out_valid = e_v_reg;
    assign num       = e_num_reg;
    assign den       = e_den_reg;
    assign side      = e_side_reg;

endmodule

// ===== rtl/mts_div.sv =====
// Pipelined restoring divider: round(PIXEL_MAX * num / den) with saturation.
module mts_div #(
    parameter int PIXEL_BITS = mts_pkg::PIXEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [mts_pkg::DW-1:0] num,
    input  logic signed [mts_pkg::DW-1:0] den,
    input  mts_pkg::side_t                side,
    output logic                          out_valid,
    output logic [mts_pkg::PIX_W-1:0]     pixel_out
);
    import mts_pkg::*;

    localparam logic [PIX_W-1:0] PMAX = pix_max(PIXEL_BITS);
    localparam int RW = MW + PIXEL_BITS;

    // stage F: sign tests and magnitudes
    logic          f_v_reg, f_v_next;
    side_t         f_side_reg, f_side_next;
    logic [MW-1:0] f_un_reg, f_un_next;
    logic [MW-1:0] f_ud_reg, f_ud_next;
    logic [DW-1:0] f_nabs, f_dabs;

    always_comb
    begin
        f_nabs      = num[DW-1] ? DW'(-num) : num;
        f_dabs      = den[DW-1] ? DW'(-den) : den;
        f_v_next    = in_valid;
        f_side_next = side;
        f_un_next   = f_nabs[MW-1:0];
        f_ud_next   = f_dabs[MW-1:0];
        if (!side.bypass && !side.fixed)
        begin
            if (den == '0)
            begin
                f_side_next.fixed = 1'b1;
                f_side_next.value = PMAX;
            end
            else if (num == '0 || (num[DW-1] != den[DW-1]))
            begin
                f_side_next.fixed = 1'b1;
                f_side_next.value = '0;
            end
        end
    end

    // stage G: ratio at or above one saturates, form dividend
    logic          g_v_reg, g_v_next;
    side_t         g_side_reg, g_side_next;
    logic [RW-1:0] g_r_reg, g_r_next;
    logic [MW-1:0] g_ud_reg, g_ud_next;

    always_comb
    begin
        g_v_next    = f_v_reg;
        g_side_next = f_side_reg;
        g_ud_next   = f_ud_reg;
        g_r_next    = {f_un_reg, {PIXEL_BITS{1'b0}}} - RW'(f_un_reg);
        if (!f_side_reg.bypass && !f_side_reg.fixed && (f_un_reg >= f_ud_reg))
        begin
            g_side_next.fixed = 1'b1;
            g_side_next.value = PMAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= f_v_next;
            g_v_reg <= g_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_side_reg <= f_side_next;
            f_un_reg   <= f_un_next;
            f_ud_reg   <= f_ud_next;
            g_side_reg <= g_side_next;
            g_r_reg    <= g_r_next;
            g_ud_reg   <= g_ud_next;
        end
    end

    // quotient stages, one bit each, most significant first
    logic                  q_v_reg    [PIXEL_BITS];
    side_t                 q_side_reg [PIXEL_BITS];
    logic [RW-1:0]         q_r_reg    [PIXEL_BITS];
    logic [MW-1:0]         q_ud_reg   [PIXEL_BITS];
    logic [PIXEL_BITS-1:0] q_q_reg    [PIXEL_BITS];

    for (genvar k = 0; k < PIXEL_BITS; k++)
    begin : g_qstage
        localparam int BIT = PIXEL_BITS - 1 - k;

        logic                  v_in;
        side_t                 side_in;
        logic [RW-1:0]         r_in;
        logic [MW-1:0]         ud_in;
        logic [PIXEL_BITS-1:0] q_in;
        logic [RW-1:0]         dsh;
        logic                  take;
        logic [RW-1:0]         r_next;
        logic [PIXEL_BITS-1:0] q_next;

        if (k == 0)
        begin : g_first
            assign v_in    = g_v_reg;
            assign side_in = g_side_reg;
            assign r_in    = g_r_reg;
            assign ud_in   = g_ud_reg;
            assign q_in    = '0;
        end
        else
        begin : g_rest
            assign v_in    = q_v_reg[k-1];
            assign side_in = q_side_reg[k-1];
            assign r_in    = q_r_reg[k-1];
            assign ud_in   = q_ud_reg[k-1];
            assign q_in    = q_q_reg[k-1];
        end

        // subtract the shifted divisor where it fits
        always_comb
        begin
            dsh    = RW'(ud_in) << BIT;
            take   = r_in >= dsh;
            r_next = take ? (r_in - dsh) : r_in;
            q_next = q_in;
            if (take)
            begin
                q_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                q_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                q_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_side_reg[k] <= side_in;
                q_r_reg[k]    <= r_next;
                q_ud_reg[k]   <= ud_in;
                q_q_reg[k]    <= q_next;
            end
        end
    end

    // final stage: round half up on remainder, saturate, merge fixed results
    logic                out_v_reg, out_v_next;
    logic [PIX_W-1:0]    pix_reg, pix_next;
    logic [RW:0]         r_dbl;
    logic [PIXEL_BITS:0] q_rnd;
    logic [PIX_W-1:0]    q_sat;

    always_comb
    begin
        r_dbl      = {q_r_reg[PIXEL_BITS-1], 1'b0};
        q_rnd      = {1'b0, q_q_reg[PIXEL_BITS-1]}
                     + (PIXEL_BITS+1)'(r_dbl >= (RW+1)'(q_ud_reg[PIXEL_BITS-1]));
        q_sat      = (q_rnd > (PIXEL_BITS+1)'(PMAX)) ? PMAX : PIX_W'(q_rnd);
        out_v_next = q_v_reg[PIXEL_BITS-1];
        if (q_side_reg[PIXEL_BITS-1].bypass || q_side_reg[PIXEL_BITS-1].fixed)
        begin
            pix_next = q_side_reg[PIXEL_BITS-1].value;
        end
        else
        begin
            pix_next = q_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = out_v_reg;
    assign pixel_out = pix_reg;

endmodule

// ===== rtl/midtones_transfer_stretch_top.sv =====
// Top level of the midtones transfer stretch: config registers and pipeline control.
//
// Input channel: in_valid/in_ready carry one sample (pixel_in) and its colour
// plane (channel) per beat. Output channel: out_valid/out_ready carry the
// stretched sample (pixel_out). One result beat leaves for every input beat,
// in order.
// Five stages build the rational numerator and divisor, two classify and form the
// dividend, PIXEL_BITS stages of the restoring divider retire one quotient bit each,
// and one stage rounds, saturates and holds the result. Throughput is one beat per
// cycle while the receiver does not stall; every stage advances together.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops; no beat is lost or repeated, and every stage advances again
// in the cycle the output register drains or is empty.
// Reset clears all valid bits and loads the register defaults: shadows 0,
// balance one half, highlights 1.0, forward curve, all planes on, full scale
// 65535. Registers are written through write_en/reg_index/write_data; the user
// must write them only while idle, and the block itself does not enforce it.
module midtones_transfer_stretch_top #(
    parameter int PIXEL_BITS = mts_pkg::PIXEL_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         write_en,
    input  logic [mts_pkg::IDX_W-1:0]    reg_index,
    input  logic [mts_pkg::DATA_W-1:0]   write_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mts_pkg::PIX_W-1:0]    pixel_in,
    input  logic [mts_pkg::CH_W-1:0]     channel,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mts_pkg::PIX_W-1:0]    pixel_out
);
    import mts_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic [LEVEL_W-1:0] lvl;
    logic adv;

    // clamp levels to 1.0, keep full scale nonzero
    always_comb
    begin
        lvl      = (write_data > DATA_W'(UNIT)) ? LEVEL_W'(UNIT) : write_data;
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (reg_index)
                REG_SHADOWS:    cfg_next.shadows    = lvl;
                REG_MIDTONES:   cfg_next.midtones   = lvl;
                REG_HIGHLIGHTS: cfg_next.highlights = lvl;
                REG_INVERSE:    cfg_next.inverse    = write_data[0];
                REG_CH_ENABLE:  cfg_next.ch_enable  = write_data[2:0];
                REG_FULL_SCALE: cfg_next.full_scale =
                    (write_data[FS_W-1:0] == '0) ? FS_W'(1) : write_data[FS_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shadows    <= '0;
            cfg_reg.midtones   <= LEVEL_W'(UNIT / 2);
            cfg_reg.highlights <= LEVEL_W'(UNIT);
            cfg_reg.inverse    <= 1'b0;
            cfg_reg.ch_enable  <= 3'b111;
            cfg_reg.full_scale <= FS_W'(UNIT - 1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // advance everything unless a result is waiting on the receiver
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    logic                  fr_valid;
    logic signed [DW-1:0]  fr_num;
    logic signed [DW-1:0]  fr_den;
    side_t                 fr_side;

    mts_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .pixel_in  (pixel_in),
        .channel   (channel),
        .out_valid (fr_valid),
        .num       (fr_num),
        .den       (fr_den),
        .side      (fr_side)
    );

    mts_div #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fr_valid),
        .num       (fr_num),
        .den       (fr_den),
        .side      (fr_side),
        .out_valid (out_valid),
        .pixel_out (pixel_out)
    );

endmodule

// ===== rtl/mts_checker.sv =====
// Port-level assertions for the midtones transfer stretch, bound to the top level.
module mts_assertions (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [mts_pkg::PIX_W-1:0]    pixel_out
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out))
        else $error("stalled output beat changed");

    // accept input whenever the output register is empty
    a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output");

    // accept input in the cycle a result beat drains
    a_take_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input refused while output drains");

    // freeze intake while the receiver stalls
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

endmodule

bind midtones_transfer_stretch_top mts_assertions u_mts_assertions (.*);

// ===== test/mts_checker.sv =====
// Checker for the midtones transfer stretch: predicts each result and compares it.
`timescale 1ns / 1ps
module mts_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       write_en,
    input  logic [mts_pkg::IDX_W-1:0]  reg_index,
    input  logic [mts_pkg::DATA_W-1:0] write_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [mts_pkg::PIX_W-1:0]  pixel_in,
    input  logic [mts_pkg::CH_W-1:0]   channel,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [mts_pkg::PIX_W-1:0]  pixel_out,
    output int                         fail_count,
    output int                         pending
);
    import mts_pkg::*;

    localparam longint PMAX = 65535;
    localparam longint ONE  = 65536;

    logic [16:0] shadows_q, balance_q, highlights_q;
    logic        inverse_q;
    logic [2:0]  enable_q;
    logic [15:0] scale_q;
    logic [15:0] expected_pixels[$];

    function automatic longint clamp_level(logic [16:0] v);
        return (v > 17'd65536) ? ONE : longint'(v);
    endfunction

    // round(PMAX * num / den), ties away from zero, saturated
    function automatic logic [15:0] scaled_quotient(longint num, longint den);
        longint un, ud, q, r;
        logic [79:0] prod;
        if (den == 0) return 16'hFFFF;
        if (num == 0) return 16'd0;
        if ((num < 0) != (den < 0)) return 16'd0;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        if (un >= ud) return 16'hFFFF;
        prod = 80'(un) * 80'(PMAX);
        q = longint'(prod / 80'(ud));
        r = longint'(prod % 80'(ud));
        if (2 * r >= ud) q++;
        if (q > PMAX) q = PMAX;
        return 16'(q);
    endfunction

    function automatic logic [15:0] stretch_pixel(logic [15:0] pix, logic [1:0] ch);
        longint p, f, s, m, h, num, den, px, sf, hf, a, b;
        p = longint'(pix);
        f = (scale_q == 0) ? 1 : longint'(scale_q);
        s = clamp_level(shadows_q);
        m = clamp_level(balance_q);
        h = clamp_level(highlights_q);
        if (ch > 2'd2 || !enable_q[ch]) return pix;
        if (inverse_q) begin
            num = ((s + h) * m - s * ONE) * p + s * (ONE - m) * f;
            den = (2 * m - ONE) * ONE * p + (ONE - m) * ONE * f;
            return scaled_quotient(num, den);
        end
        px = p * ONE;
        sf = s * f;
        hf = h * f;
        if (px <= sf) return 16'd0;
        if (px >= hf) return 16'hFFFF;
        a = px - sf;
        b = (h - s) * f;
        return scaled_quotient((m - ONE) * a, (2 * m - ONE) * a - m * b);
    endfunction

    // track registers, predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadows_q    <= 17'd0;
            balance_q    <= 17'd32768;
            highlights_q <= 17'd65536;
            inverse_q    <= 1'b0;
            enable_q     <= 3'd7;
            scale_q      <= 16'd65535;
            fail_count   <= 0;
            pending      <= 0;
        end
        else
        begin
            if (write_en)
            begin
                case (reg_index)
                    REG_SHADOWS:    shadows_q    <= write_data;
                    REG_MIDTONES:   balance_q    <= write_data;
                    REG_HIGHLIGHTS: highlights_q <= write_data;
                    REG_INVERSE:    inverse_q    <= write_data[0];
                    REG_CH_ENABLE:  enable_q     <= write_data[2:0];
                    REG_FULL_SCALE: scale_q      <= write_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(stretch_pixel(pixel_in, channel));
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected beat, actual pixel_out %0d", $time, pixel_out);
                    fail_count <= fail_count + 1;
                end
                else if (expected_pixels[0] !== pixel_out)
                begin
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $time, expected_pixels[0], pixel_out);
                    fail_count <= fail_count + 1;
                    void'(expected_pixels.pop_front());
                end
                else
                    void'(expected_pixels.pop_front());
            end
            pending <= expected_pixels.size();
        end
    end
endmodule

// ===== test/testbench.sv =====
// Testbench top: stimulus, register phases and the verdict for the stretch block.
`timescale 1ns / 1ps
module testbench;
    import mts_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               write_en;
    logic [IDX_W-1:0]   reg_index;
    logic [DATA_W-1:0]  write_data;
    logic               in_valid, in_ready, out_valid, out_ready;
    logic [PIX_W-1:0]   pixel_in, pixel_out;
    logic [CH_W-1:0]    channel;
    int                 fail_count, pending;
    longint             cycle_count;

    midtones_transfer_stretch_top u_dut (
        .clk(clk), .rst_n(rst_n), .write_en(write_en), .reg_index(reg_index),
        .write_data(write_data), .in_valid(in_valid), .in_ready(in_ready),
        .pixel_in(pixel_in), .channel(channel), .out_valid(out_valid),
        .out_ready(out_ready), .pixel_out(pixel_out)
    );

    mts_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // stop a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("midtones_transfer_stretch_top test failed");
                $finish;
            end
        end
    end

    // receiver: random stall before each beat
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // drive one write; the caller drops write_en after the last one
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        write_en   <= 1'b1;
        reg_index  <= idx;
        write_data <= value;
        @(posedge clk);
    endtask

    task automatic send_beat(logic [15:0] pix, logic [1:0] ch, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= pix;
        channel  <= ch;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // wait until every result is back, then let the pipeline drain
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_all(logic [16:0] s, logic [16:0] m, logic [16:0] h,
                           bit inv, logic [2:0] en, logic [15:0] fs);
        write_reg(REG_SHADOWS, s);
        write_reg(REG_MIDTONES, m);
        write_reg(REG_HIGHLIGHTS, h);
        write_reg(REG_INVERSE, DATA_W'(inv));
        write_reg(REG_CH_ENABLE, DATA_W'(en));
        write_reg(REG_FULL_SCALE, DATA_W'(fs));
        write_en <= 1'b0;
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_level();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'd65536 + 17'($urandom_range(1, 65535));
            3: return 17'd32768;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial
    begin
        bit burst;
        rst_n = 1'b0;
        write_en = 1'b0; reg_index = '0; write_data = '0;
        in_valid = 1'b0; pixel_in = '0; channel = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: extremes, every plane incl. unused plane three
        send_beat(16'd0, 2'd0, 1'b0);
        send_beat(16'hFFFF, 2'd1, 1'b0);
        send_beat(16'd32768, 2'd2, 1'b0);
        send_beat(16'hA5A5, 2'd3, 1'b0);
        drain();
        // crossed levels, level above one, zero full scale, disabled planes
        set_all(17'd40000, 17'h1FFFF, 17'd20000, 1'b0, 3'd2, 16'd0);
        send_beat(16'd0, 2'd0, 1'b0);
        send_beat(16'd1, 2'd1, 1'b0);
        send_beat(16'hFFFF, 2'd1, 1'b0);
        send_beat(16'h5A5A, 2'd2, 1'b0);
        drain();
        // inverse with extreme balances, zero divisor cases
        set_all(17'd0, 17'd0, 17'd65536, 1'b1, 3'd7, 16'd1);
        send_beat(16'd0, 2'd0, 1'b0);
        send_beat(16'd1, 2'd1, 1'b0);
        send_beat(16'hFFFF, 2'd2, 1'b0);
        drain();
        set_all(17'd65536, 17'd65536, 17'd0, 1'b1, 3'd7, 16'd65535);
        send_beat(16'd0, 2'd0, 1'b0);
        send_beat(16'd30000, 2'd1, 1'b0);
        send_beat(16'hFFFF, 2'd2, 1'b0);
        drain();
        set_all(17'd1000, 17'd100, 17'd60000, 1'b0, 3'd7, 16'd65535);
        repeat (8) send_beat(rand_pixel(), 2'($urandom_range(0, 2)), 1'b0);
        drain();

        // random phases with fresh settings
        for (int ph = 0; ph < 32; ph++)
        begin
            set_all(rand_level(), rand_level(), rand_level(), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd7,
                    ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom));
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 50; i++)
                send_beat(rand_pixel(), 2'($urandom_range(0, 15) == 0 ? 3
                                           : $urandom_range(0, 2)), burst);
            drain();
        end

        if (fail_count == 0)
            $display("midtones_transfer_stretch_top test passed");
        else
            $display("midtones_transfer_stretch_top test failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/mts_pkg.sv
rtl/mts_front.sv
rtl/mts_div.sv
rtl/midtones_transfer_stretch_top.sv
rtl/mts_checker.sv
test/mts_checker.sv
test/testbench.sv
